FILE: sv/ictl_pkg.sv
// Shared types and constants for the IPv4 country trie lookup unit.
// Used by ictl_ctrl, ictl_datapath and ipv4_country_trie_lookup_unit.
package ictl_pkg;

  localparam int unsigned TREE_DEPTH   = 262144;
  localparam int unsigned NODE_W       = $clog2(TREE_DEPTH);
  localparam int unsigned ADDRESS_BITS = 32;
  localparam int unsigned LEVEL_W      = $clog2(ADDRESS_BITS);
  localparam int unsigned REC_W        = 24;
  localparam int unsigned ENTRY_W      = 2 * REC_W;
  localparam int unsigned LIMIT_W      = 19;
  localparam int unsigned ID_W         = 8;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 24;

  // Stream payload layout, lowest bit first.
  localparam int unsigned IN_DATA_W    = 104;
  localparam int unsigned OUT_DATA_W   = 8;

  localparam logic [REC_W-1:0] LEAF_BASE_RST = 24'd16776960;

  // Octets of the filtered address ranges.
  localparam logic [7:0] OCT_PRIV_A    = 8'd10;
  localparam logic [7:0] OCT_LOOPBACK  = 8'd127;
  localparam logic [7:0] OCT_PRIV_C_HI = 8'd192;
  localparam logic [7:0] OCT_PRIV_C_LO = 8'd168;
  localparam logic [7:0] OCT_PRIV_B_HI = 8'd172;
  localparam logic [7:0] OCT_PRIV_B_MIN = 8'd16;
  localparam logic [7:0] OCT_PRIV_B_MAX = 8'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_LIMIT = 1'b0,
    REG_LEAF_BASE  = 1'b1
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_WRITE   = 3'd0,
    ST_FOUND   = 3'd1,
    ST_PRIVATE = 3'd2,
    ST_NONE    = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  typedef struct packed {
    logic    take;        // input beat accepted this cycle
    logic    set_res;     // capture a result code
    status_e res_status;
    logic    read_root;   // read node 0 and start the walk
    logic    step;        // follow the selected record one level down
    logic    push;        // move the result into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic in_func;
    logic filtered;
    logic limit_zero;
    logic leaf;
    logic id_ok;
    logic last_level;
    logic beyond;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: sv/ictl_ctrl.sv
// Sequencer of the trie lookup: accepts beats, walks the tree level by level
// and hands results to the output register. Depends on ictl_pkg.
module ictl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ictl_pkg::dp_stat_t stat_i,
  output ictl_pkg::ctl_cmd_t cmd_o
);
  import ictl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILT,
    S_WALK,
    S_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.res_status   = ST_WRITE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.take = 1'b1;
          if (stat_i.in_func == FUNC_WRITE) begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = ST_WRITE;
            state_d          = S_HOLD;
          end else begin
            state_d = S_FILT;
          end
        end
      end
      S_FILT: begin
        if (stat_i.filtered) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_PRIVATE;
          state_d          = S_HOLD;
        end else if (stat_i.limit_zero) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_RANGE;
          state_d          = S_HOLD;
        end else begin
          cmd_o.read_root = 1'b1;
          state_d         = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.leaf) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = stat_i.id_ok ? ST_FOUND : ST_NONE;
          state_d          = S_HOLD;
        end else if (stat_i.last_level) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_NONE;
          state_d          = S_HOLD;
        end else if (stat_i.beyond) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_RANGE;
          state_d          = S_HOLD;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_HOLD: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

FILE: sv/ictl_datapath.sv
// Datapath of the trie lookup: tree memory, configuration registers, address
// filter, walk registers and the output register. Depends on ictl_pkg.
module ictl_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ictl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ictl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [ictl_pkg::IN_DATA_W-1:0]     in_data_i,
  input  logic                               in_func_i,
  output logic [ictl_pkg::OUT_DATA_W-1:0]    out_data_o,
  output logic [ictl_pkg::STATUS_W-1:0]      out_status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  input  ictl_pkg::ctl_cmd_t                 cmd_i,
  output ictl_pkg::dp_stat_t                 stat_o
);
  import ictl_pkg::*;

  logic [ENTRY_W-1:0]      tree_mem [TREE_DEPTH];

  logic [LIMIT_W-1:0]      node_limit_q;
  logic [REC_W-1:0]        leaf_base_q;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [LEVEL_W-1:0]      level_q;
  logic [ENTRY_W-1:0]      rd_q;
  logic [STATUS_W-1:0]     res_status_q;
  logic [ID_W-1:0]         res_id_q;
  logic                    out_valid_q;
  logic [STATUS_W-1:0]     out_status_q;
  logic [ID_W-1:0]         out_id_q;

  logic [NODE_W-1:0]       wr_idx;
  logic [REC_W-1:0]        wr_left;
  logic [REC_W-1:0]        wr_right;
  logic [ADDRESS_BITS-1:0] in_addr;
  logic [REC_W-1:0]        rec;
  logic [REC_W-1:0]        diff;
  logic [NODE_W-1:0]       rd_addr;
  logic [7:0]              oct1;
  logic [7:0]              oct2;

  assign wr_idx   = in_data_i[NODE_W-1:0];
  assign wr_left  = in_data_i[NODE_W +: REC_W];
  assign wr_right = in_data_i[NODE_W+REC_W +: REC_W];
  assign in_addr  = in_data_i[NODE_W+2*REC_W +: ADDRESS_BITS];

  // The top address bit picks the right child when set.
  assign rec  = addr_q[ADDRESS_BITS-1] ? rd_q[REC_W-1:0] : rd_q[ENTRY_W-1:REC_W];
  assign diff = rec - leaf_base_q;
  assign oct1 = addr_q[ADDRESS_BITS-1 -: 8];
  assign oct2 = addr_q[ADDRESS_BITS-9 -: 8];
  assign rd_addr = cmd_i.read_root ? '0 : rec[NODE_W-1:0];

  always_comb begin
    stat_o            = '0;
    stat_o.in_func    = in_func_i;
    stat_o.filtered   = (addr_q == '0) || (oct1 == OCT_PRIV_A) || (oct1 == OCT_LOOPBACK)
                     || ((oct1 == OCT_PRIV_C_HI) && (oct2 == OCT_PRIV_C_LO))
                     || ((oct1 == OCT_PRIV_B_HI) && (oct2 >= OCT_PRIV_B_MIN)
                         && (oct2 <= OCT_PRIV_B_MAX));
    stat_o.limit_zero = (node_limit_q == '0);
    stat_o.leaf       = (rec >= leaf_base_q);
    stat_o.id_ok      = (diff[REC_W-1:ID_W] == '0) && (diff[ID_W-1:0] != '0);
    stat_o.last_level = (level_q == LEVEL_W'(ADDRESS_BITS - 1));
    stat_o.beyond     = ({{(REC_W-LIMIT_W){1'b0}}, node_limit_q} <= rec)
                     || (rec >= REC_W'(TREE_DEPTH));
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && (in_func_i == FUNC_WRITE)) begin
      tree_mem[wr_idx] <= {wr_left, wr_right};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_root || cmd_i.step) begin
      rd_q <= tree_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_limit_q <= '0;
      leaf_base_q  <= LEAF_BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NODE_LIMIT: node_limit_q <= cfg_data_i[LIMIT_W-1:0];
        REG_LEAF_BASE:  leaf_base_q  <= cfg_data_i[REC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      addr_q <= in_addr;
    end else if (cmd_i.step) begin
      addr_q <= {addr_q[ADDRESS_BITS-2:0], 1'b0};
    end
    if (cmd_i.read_root) begin
      level_q <= '0;
    end else if (cmd_i.step) begin
      level_q <= level_q + 1'b1;
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_id_q     <= (cmd_i.res_status == ST_FOUND) ? diff[ID_W-1:0] : '0;
    end
    if (cmd_i.push) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_id_q;
  assign out_status_o = out_status_q;

endmodule

FILE: sv/ipv4_country_trie_lookup_unit.sv
// IPv4 country trie lookup unit, top level.
// Joins the sequencer ictl_ctrl and ictl_datapath; depends on ictl_pkg.
//
// Usage: every input beat carries either a tree node write (tuser = 0) or an
// address lookup (tuser = 1). A node write stores the left and right child
// records of one node and answers with status "write done". A lookup first
// rejects the zero address, loopback and the private ranges, then walks the
// tree from node 0, one address bit per level, most significant bit first.
// Every input beat yields exactly one output beat: country id in tdata and
// status in tuser.
// Flow: a write passes from acceptance through the hold state to the output
// register; a lookup passes the filter state, then reads L (0 to 32) tree levels,
// one per cycle from the single memory port, before the hold state. One item is
// handled at a time: the next beat is taken only after the result is pushed.
// The output register holds a finished result while the next beat is
// accepted and processed; when the receiver stalls, the engine waits with its
// next result until the register frees up, and input stays blocked then.
// Reset clears the control state and sets node_limit to 0 and the leaf base to its
// default; the tree memory is not cleared, and only written nodes may be reached
// by a walk. The user writes configuration while the unit is idle (unenforced).
module ipv4_country_trie_lookup_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ictl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ictl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: node_index[17:0], left_record[41:18], right_record[65:42],
  //        address[97:66], zero fill[103:98]
  input  logic [ictl_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // tuser: func[0]
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: country_id[7:0]
  output logic [ictl_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // tuser: status[2:0]
  output logic [ictl_pkg::STATUS_W-1:0]     m_axis_tuser_o
);
  import ictl_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ictl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ictl_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata_i),
    .in_func_i    (s_axis_tuser_i),
    .out_data_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule
